FILE: design/tc_pkg.sv
// tc_pkg: shared types, character codes and the keyword table of the token classifier.
// Used by every design module and by the checker; depends on nothing.
package tc_pkg;

  // Result kinds as they appear on the output word
  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_NUMBER  = 3'd1,
    KIND_STRING  = 3'd2,
    KIND_IDENT   = 3'd3,
    KIND_UNKNOWN = 3'd4,
    KIND_OPER    = 3'd5,
    KIND_PUNCT   = 3'd6
  } kind_e;

  // One result word, before packing onto the stream
  typedef struct packed {
    logic [2:0]  keyword_index;
    logic [15:0] token_length;
    logic [7:0]  symbol;
    kind_e       kind;
  } result_t;

  // Up to two results caused by one text byte: word token first, then symbol
  typedef struct packed {
    logic    word_valid;
    result_t word;
    logic    sym_valid;
    result_t sym;
  } res_pair_t;

  localparam int          KW_SLOTS   = 16;
  localparam int          KW_SLOT_W  = 4;
  localparam int          KW_POS_W   = 3;
  localparam int          RESULT_W   = 30;
  localparam int          TDATA_W    = 32;
  localparam logic [15:0] TOKLEN_MAX = 16'hFFFF;

  // Character codes
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  // Keyword text, right aligned (last character in the low byte)
  function automatic logic [63:0] kw_text(input logic [KW_SLOT_W-1:0] slot);
    case (slot)
      4'd0:    return 64'("int");
      4'd1:    return 64'("float");
      4'd2:    return 64'("double");
      4'd3:    return 64'("char");
      4'd4:    return 64'("cout");
      4'd5:    return 64'("cin");
      4'd6:    return 64'("return");
      default: return 64'd0;
    endcase
  endfunction

  // Keyword length; empty slots have length zero and never match
  function automatic logic [3:0] kw_len(input logic [KW_SLOT_W-1:0] slot);
    case (slot)
      4'd0:    return 4'd3;
      4'd1:    return 4'd5;
      4'd2:    return 4'd6;
      4'd3:    return 4'd4;
      4'd4:    return 4'd4;
      4'd5:    return 4'd3;
      4'd6:    return 4'd6;
      default: return 4'd0;
    endcase
  endfunction

  // Character of a keyword at a position; only meaningful below kw_len
  function automatic logic [7:0] kw_char(input logic [KW_SLOT_W-1:0] slot,
                                         input logic [KW_POS_W-1:0] pos);
    logic [63:0]         t;
    logic [KW_POS_W-1:0] b;
    t = kw_text(slot);
    b = KW_POS_W'(kw_len(slot) - 4'(pos) - 4'd1);
    return t[8*b +: 8];
  endfunction

endpackage

FILE: design/tc_track.sv
// tc_track: running token facts and the single-pass classification of one byte.
// Depends on tc_pkg.
module tc_track #(
  parameter int KEYWORD_COUNT = 7,
  parameter int LENGTH_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,  // byte in the input register moves on
  input  logic [7:0]         char_i,
  output tc_pkg::res_pair_t  pair_o
);

  localparam logic [2:0] KW_NONE = 3'(KEYWORD_COUNT);
  localparam int         TW      = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic [KEYWORD_COUNT-1:0] alive_q, alive_d;
  logic digits_q, digits_d;
  logic fquote_q, fquote_d;
  logic fletter_q, fletter_d;
  logic lquote_q, lquote_d;

  logic is_op, is_punct, is_delim, is_digit, is_letter, has_tok;
  logic [2:0]  kw_idx;
  logic        kw_hit;
  logic [TW-1:0] len_ext;
  logic [15:0] tok_len;
  tc_pkg::kind_e word_kind;

  // Byte classes
  always_comb begin
    is_op    = char_i inside {tc_pkg::CH_PLUS, tc_pkg::CH_MINUS, tc_pkg::CH_STAR,
                              tc_pkg::CH_SLASH, tc_pkg::CH_EQ, tc_pkg::CH_LT, tc_pkg::CH_GT};
    is_punct = char_i inside {tc_pkg::CH_SEMI, tc_pkg::CH_COMMA, tc_pkg::CH_LPAR,
                              tc_pkg::CH_RPAR, tc_pkg::CH_LBRACE, tc_pkg::CH_RBRACE};
    is_delim = is_op || is_punct || (char_i == tc_pkg::CH_LF) || (char_i == tc_pkg::CH_SPACE);
    is_digit = char_i inside {[tc_pkg::CH_0 : tc_pkg::CH_9]};
    is_letter = (char_i inside {[tc_pkg::CH_LA : tc_pkg::CH_LZ]}) ||
                (char_i inside {[tc_pkg::CH_UA : tc_pkg::CH_UZ]}) ||
                (char_i == tc_pkg::CH_UNDER);
    has_tok  = (len_q != '0);
  end

  // Keyword hit: lowest surviving slot whose length is exact
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = KW_NONE;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (alive_q[i] && (tc_pkg::kw_len(tc_pkg::KW_SLOT_W'(i)) != 4'd0) &&
          (len_q == LENGTH_BITS'(tc_pkg::kw_len(tc_pkg::KW_SLOT_W'(i))))) begin
        kw_hit = 1'b1;
        kw_idx = 3'(i);
      end
    end
  end

  // Word class and saturated length
  always_comb begin
    len_ext = TW'(len_q);
    tok_len = (len_ext > TW'(tc_pkg::TOKLEN_MAX)) ? tc_pkg::TOKLEN_MAX : len_ext[15:0];
    if (kw_hit)                     word_kind = tc_pkg::KIND_KEYWORD;
    else if (digits_q)              word_kind = tc_pkg::KIND_NUMBER;
    else if (fquote_q && lquote_q)  word_kind = tc_pkg::KIND_STRING;
    else if (fletter_q)             word_kind = tc_pkg::KIND_IDENT;
    else                            word_kind = tc_pkg::KIND_UNKNOWN;
  end

  // Results caused by this byte
  always_comb begin
    pair_o.word_valid          = is_delim && has_tok;
    pair_o.word.kind           = word_kind;
    pair_o.word.symbol         = 8'd0;
    pair_o.word.token_length   = tok_len;
    pair_o.word.keyword_index  = kw_idx;
    pair_o.sym_valid           = is_op || is_punct;
    pair_o.sym.kind            = is_op ? tc_pkg::KIND_OPER : tc_pkg::KIND_PUNCT;
    pair_o.sym.symbol          = char_i;
    pair_o.sym.token_length    = 16'd1;
    pair_o.sym.keyword_index   = KW_NONE;
  end

  // Next token state: delimiters clear, token bytes extend
  always_comb begin
    len_d     = len_q;
    alive_d   = alive_q;
    digits_d  = digits_q;
    fquote_d  = fquote_q;
    fletter_d = fletter_q;
    lquote_d  = lquote_q;
    if (advance_i) begin
      if (is_delim) begin
        len_d     = '0;
        alive_d   = '1;
        digits_d  = 1'b1;
        fquote_d  = 1'b0;
        fletter_d = 1'b0;
        lquote_d  = 1'b0;
      end else begin
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
          alive_d[i] = alive_q[i] &&
                       (len_q < LENGTH_BITS'(tc_pkg::kw_len(tc_pkg::KW_SLOT_W'(i)))) &&
                       (tc_pkg::kw_char(tc_pkg::KW_SLOT_W'(i), len_q[tc_pkg::KW_POS_W-1:0])
                        == char_i);
        end
        if (!has_tok) begin
          fquote_d  = (char_i == tc_pkg::CH_QUOTE);
          fletter_d = is_letter;
        end
        digits_d = digits_q && is_digit;
        lquote_d = (char_i == tc_pkg::CH_QUOTE);
        if (len_q != '1) len_d = len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      alive_q   <= '1;
      digits_q  <= 1'b1;
      fquote_q  <= 1'b0;
      fletter_q <= 1'b0;
      lquote_q  <= 1'b0;
    end else begin
      len_q     <= len_d;
      alive_q   <= alive_d;
      digits_q  <= digits_d;
      fquote_q  <= fquote_d;
      fletter_q <= fletter_d;
      lquote_q  <= lquote_d;
    end
  end

endmodule

FILE: design/tc_outbuf.sv
// tc_outbuf: result register holding up to two results of one byte and
// sending them out in order. Depends on tc_pkg.
module tc_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  tc_pkg::res_pair_t           pair_i,
  output logic                        load_ok_o,   // register can take a pair this cycle
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [tc_pkg::TDATA_W-1:0]  m_axis_tdata_o,  // kind, symbol, token_length, keyword_index
  output logic                        m_axis_tlast_o
);

  logic            wv_q, wv_d, sv_q, sv_d;
  tc_pkg::result_t word_q, sym_q;
  tc_pkg::result_t cur;
  logic            fire;

  // Word result goes first; it is last only when no symbol follows
  always_comb begin
    cur             = wv_q ? word_q : sym_q;
    m_axis_tvalid_o = wv_q || sv_q;
    m_axis_tlast_o  = !(wv_q && sv_q);
    m_axis_tdata_o  = {(tc_pkg::TDATA_W - tc_pkg::RESULT_W)'(0), cur};
    fire            = m_axis_tvalid_o && m_axis_tready_i;
    load_ok_o       = !(wv_q || sv_q) || (m_axis_tready_i && (wv_q ^ sv_q));
  end

  // Valid bits: pop the front word, then load a new pair
  always_comb begin
    wv_d = wv_q;
    sv_d = sv_q;
    if (fire) begin
      if (wv_q) wv_d = 1'b0;
      else      sv_d = 1'b0;
    end
    if (load_i) begin
      wv_d = pair_i.word_valid;
      sv_d = pair_i.sym_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      wv_q <= wv_d;
      sv_q <= sv_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= pair_i.word;
      sym_q  <= pair_i.sym;
    end
  end

endmodule

FILE: design/token_classifier.sv
// token_classifier: top level of the byte-stream token classifier.
// Instantiates tc_track and tc_outbuf; depends on tc_pkg.
//
//  channel   dir  payload                                          end marker
//  s_axis    in   tdata[7:0] char_code                             -
//  m_axis    out  tdata kind, symbol, token_length, keyword_index  tlast = last
//
// One byte is taken per cycle unless the output stalls or a byte causes two
// results. A byte waits in the input register, is classified and lands in the
// result register. A byte that causes two results (a token flushed by an
// operator or punctuation) holds the result register until its word result is
// sent, which stalls the input. Reset clears the token state at once.
// Output stalls back up through the result register into the input register.
module token_classifier #(
  parameter int KEYWORD_COUNT = 7,
  parameter int LENGTH_BITS   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // char_code
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // kind[2:0], symbol[10:3], token_length[26:11], keyword_index[29:27], zero pad
  output logic [tc_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);

  logic              in_v_q;
  logic [7:0]        char_q;
  logic              load_ok, advance;
  tc_pkg::res_pair_t pair;

  assign advance         = in_v_q && load_ok;
  assign s_axis_tready_o = !in_v_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) char_q <= s_axis_tdata_i;
  end

  tc_track #(
    .KEYWORD_COUNT (KEYWORD_COUNT),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .char_i    (char_q),
    .pair_o    (pair)
  );

  tc_outbuf u_outbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .pair_i          (pair),
    .load_ok_o       (load_ok),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

FILE: design/tc_checker.sv
// tc_checker: port-level assertions for token_classifier, attached by bind.
// Depends on tc_pkg.
module tc_checker #(
  parameter int KEYWORD_COUNT = 7
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [tc_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  input logic                        m_axis_tlast_o
);

  localparam logic [2:0] KW_NONE = 3'(KEYWORD_COUNT);

  logic [2:0]  kind;
  logic [7:0]  symbol;
  logic [15:0] toklen;
  logic [2:0]  kwi;
  logic        sym_kind;

  assign kind     = m_axis_tdata_o[2:0];
  assign symbol   = m_axis_tdata_o[10:3];
  assign toklen   = m_axis_tdata_o[26:11];
  assign kwi      = m_axis_tdata_o[29:27];
  assign sym_kind = (kind == tc_pkg::KIND_OPER) || (kind == tc_pkg::KIND_PUNCT);

  // A stalled output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word dropped or changed while stalled");

  // Operator and punctuation words close their byte, with length one
  a_sym_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && sym_kind |-> m_axis_tlast_o && (toklen == 16'd1) && (kwi == KW_NONE))
    else $error("bad operator or punctuation word");

  // Word tokens carry no symbol and are never empty
  a_word_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !sym_kind |-> (symbol == 8'd0) && (toklen != 16'd0))
    else $error("bad word token");

  // A word that is not last is followed by the symbol of the same byte
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o && sym_kind)
    else $error("first of two results not followed by its symbol");

endmodule

bind token_classifier tc_checker #(.KEYWORD_COUNT(KEYWORD_COUNT)) u_tc_checker (.*);
